@@ rtl/cpma_pkg.sv @@
`default_nettype none

package cpma_pkg;

   // number of periods averaged
   localparam int WINDOW = 10;

   // field widths
   localparam int CaptureW = 32;
   localparam int MeanW    = 32;

   // derived widths
   localparam int CountW = $clog2(WINDOW + 1);
   localparam int SlotW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TotalW = CaptureW + $clog2(WINDOW);
   localparam int StepW  = $clog2(TotalW + 1);

   // request to the serial divider
   typedef struct packed {
      logic              start;
      logic [TotalW-1:0] dividend;
      logic [CountW-1:0] divisor;
   } div_req_type;

   // status back from the serial divider
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [TotalW-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/cpma_if.sv @@
`default_nettype none

// request channel: one timer capture per request
interface cpma_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpma_pkg::CaptureW-1:0] capture_time;

   modport source (output valid, output capture_time, input ready);
   modport sink   (input valid, input capture_time, output ready);
endinterface

// response channel: one mean period per request
interface cpma_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cpma_pkg::MeanW-1:0] mean_period;

   modport source (output valid, output mean_period, input ready);
   modport sink   (input valid, input mean_period, output ready);
endinterface

`default_nettype wire

@@ rtl/capture_period_moving_average_top.sv @@
`default_nettype none

// An accepted request passes through ring update, divider start, serial divide,
// result register and response before its response is offered.
// No new request is taken until that response is taken and the block is idle again;
// the serial divider, one quotient bit per cycle over the 36-bit window sum,
// dominates.
// Reset clears the previous capture, fill count, write slot and window sum.

module capture_period_moving_average_top (
   input  wire logic clock,
   input  wire logic reset,
   cpma_req_if.sink  req_bus,
   cpma_rsp_if.source rsp_bus
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_UPD  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [cpma_pkg::CaptureW-1:0] prev_ff, prev_in;
   logic [cpma_pkg::CaptureW-1:0] period_ff, period_in;
   logic [cpma_pkg::CountW-1:0]   fill_ff, fill_in;
   logic [cpma_pkg::SlotW-1:0]    slot_ff, slot_in;
   logic [cpma_pkg::TotalW-1:0]   total_ff, total_in;
   logic [cpma_pkg::MeanW-1:0]    mean_ff, mean_in;

   logic                          accept;
   logic                          full;
   logic [cpma_pkg::CaptureW-1:0] oldest;
   cpma_pkg::div_req_type         div_req;
   cpma_pkg::div_rsp_type         div_rsp;

   assign accept = req_bus.valid && req_bus.ready;
   assign full   = (fill_ff == cpma_pkg::CountW'(cpma_pkg::WINDOW));

   // period ring, oldest entry read as the request is taken
   cpma_ram #(
      .WIDTH (cpma_pkg::CaptureW),
      .DEPTH (cpma_pkg::WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPD),
      .wr_addr (slot_ff),
      .wr_data (period_ff),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (oldest)
   );

   // serial divider
   assign div_req.start    = (state_ff == ST_LOAD);
   assign div_req.dividend = total_ff;
   assign div_req.divisor  = fill_ff;

   cpma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer and running window state
   always_comb begin
      state_in  = state_ff;
      prev_in   = prev_ff;
      period_in = period_ff;
      fill_in   = fill_ff;
      slot_in   = slot_ff;
      total_in  = total_ff;
      mean_in   = mean_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               period_in = req_bus.capture_time - prev_ff;
               prev_in   = req_bus.capture_time;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (full) begin
               total_in = total_ff - cpma_pkg::TotalW'(oldest)
                          + cpma_pkg::TotalW'(period_ff);
            end else begin
               total_in = total_ff + cpma_pkg::TotalW'(period_ff);
               fill_in  = fill_ff + 1'b1;
            end
            if (slot_ff == cpma_pkg::SlotW'(cpma_pkg::WINDOW - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[cpma_pkg::MeanW-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         fill_ff  <= '0;
         slot_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         total_ff <= total_in;
      end
      period_ff <= period_in;
      mean_ff   <= mean_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.mean_period = mean_ff;

`ifndef SYNTHESIS
   // one request in flight: never ready while a response waits
   assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request taken while response pending");

   // fill count saturates at the window length
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cpma_pkg::CountW'(cpma_pkg::WINDOW))
      else $error("fill count beyond window");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider result outside divide state");

   // divider idle whenever the sequencer is not dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> !div_rsp.busy)
      else $error("divider busy outside divide state");

   // divisor is never zero at divider start
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (fill_ff != '0))
      else $error("divide by zero fill count");
`endif

endmodule

`default_nettype wire

@@ rtl/cpma_ram.sv @@
`default_nettype none

// generic single write, single read RAM with registered read data
module cpma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cpma_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module cpma_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cpma_pkg::div_req_type div_req,
   output cpma_pkg::div_rsp_type      div_rsp
);

   logic [cpma_pkg::TotalW-1:0] quot_ff, quot_in;
   logic [cpma_pkg::CountW-1:0] rem_ff, rem_in;
   logic [cpma_pkg::CountW-1:0] divisor_ff, divisor_in;
   logic [cpma_pkg::StepW-1:0]  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [cpma_pkg::CountW:0]   shifted;
   logic [cpma_pkg::CountW:0]   diff;
   logic                        fits;

   // one shift and trial subtract
   always_comb begin
      shifted = {rem_ff, quot_ff[cpma_pkg::TotalW-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = (shifted >= {1'b0, divisor_ff});
   end

   // sequencing of the iterations
   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[cpma_pkg::TotalW-2:0], fits};
         rem_in  = fits ? diff[cpma_pkg::CountW-1:0] : shifted[cpma_pkg::CountW-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == cpma_pkg::StepW'(cpma_pkg::TotalW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

`default_nettype wire
